### src/utf8_byte_stream_decoder_assert.svh
// Assertion macros shared by the decoder modules.
// Each expects clk and rst_n in the scope where it is used.
`ifndef UTF8_BYTE_STREAM_DECODER_ASSERT_SVH
`define UTF8_BYTE_STREAM_DECODER_ASSERT_SVH

// Check that a condition holds at every edge out of reset.
`define U8D_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("utf8 decoder invariant violated");

// Check that an antecedent implies a consequent on the same edge.
`define U8D_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("utf8 decoder implication violated");

`endif

### src/utf8d_pkg.sv
package utf8d_pkg;

  localparam int CP_W   = 21;
  localparam int PART_W = 15;
  localparam int CNT_W  = 3;

  localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;

  // One decoded byte's worth of results: cnt results, all U+FFFD except the
  // final one, which carries cp.
  typedef struct packed {
    logic             vld;
    logic [CNT_W-1:0] cnt;
    logic [CP_W-1:0]  cp;
  } burst_t;

endpackage

### src/utf8_byte_stream_decoder.sv
// A byte's burst is registered into the head slot, or the tail slot if it is busy.
// Throughput: one byte per cycle while each byte gives at most one result and
//   out_stall is low; a byte with more (up to four) plays them out one at a time.
// A two-slot burst queue sets the input stall: input holds only when both slots fill.
// Reset (rst_n low, synchronous) closes any open sequence and empties the queue.
module utf8_byte_stream_decoder
  import utf8d_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_data_byte,
  input  logic            in_text_end,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [CP_W-1:0] out_code_point,
  output logic            out_run_last
);

  // Burst handed from the decode stage to the result queue: how many results
  // this transaction yields and the value of the final one.
  burst_t push;
  logic   full;

  // Stall the input only from a register, so the two sides stay decoupled.
  assign in_stall = full;

  // Decode stage: sequence state plus single-pass classification of each byte.
  utf8d_decode u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_data_byte (in_data_byte),
    .in_text_end  (in_text_end),
    .full         (full),
    .push         (push)
  );

  // Result queue: play each burst out one code point per transaction, the
  // replacement characters first and the final value last, flagged run_last.
  utf8d_emit u_emit (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_code_point (out_code_point),
    .out_run_last   (out_run_last)
  );

endmodule

### src/utf8d_decode.sv
module utf8d_decode
  import utf8d_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_data_byte,
  input  logic       in_text_end,
  input  logic       full,
  output burst_t     push
);

`include "utf8_byte_stream_decoder_assert.svh"

  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_VAL   = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_VAL  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_VAL  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_VAL  = 8'hF0;

  logic [PART_W-1:0] partial_r, partial_nxt;
  logic [1:0]        exp_r, exp_nxt;
  logic [1:0]        held_r, held_nxt;

  logic              accept;
  logic              f_ascii;
  logic [1:0]        f_need;
  logic [4:0]        f_bits;
  logic              f_emit;
  logic              f_open;
  logic [CP_W-1:0]   f_cp;
  logic              is_cont;
  logic [CP_W-1:0]   next_val;
  logic [CNT_W-1:0]  cnt;
  logic [CP_W-1:0]   cp;

  assign accept = in_valid && !full;

  always_comb begin
    f_ascii = !in_data_byte[7];
    f_need  = 2'd0;
    f_bits  = 5'd0;
    if ((in_data_byte & LEAD2_MASK) == LEAD2_VAL) begin
      f_need = 2'd1;
      f_bits = in_data_byte[4:0];
    end else if ((in_data_byte & LEAD3_MASK) == LEAD3_VAL) begin
      f_need = 2'd2;
      f_bits = {1'b0, in_data_byte[3:0]};
    end else if ((in_data_byte & LEAD4_MASK) == LEAD4_VAL) begin
      f_need = 2'd3;
      f_bits = {2'b00, in_data_byte[2:0]};
    end
    f_open   = !f_ascii && (f_need != 2'd0) && !in_text_end;
    f_emit   = !f_open;
    f_cp     = f_ascii ? {13'd0, in_data_byte} : REPL_CP;
    is_cont  = (in_data_byte & CONT_MASK) == CONT_VAL;
    next_val = {partial_r, in_data_byte[5:0]};

    partial_nxt = partial_r;
    exp_nxt     = exp_r;
    held_nxt    = held_r;
    cnt         = '0;
    cp          = REPL_CP;

    if (exp_r == 2'd0 || !is_cont) begin
      // fresh lead, possibly after flushing an open sequence
      if (exp_r == 2'd0) begin
        cnt = {2'b00, f_emit};
      end else begin
        cnt = 3'd1 + {1'b0, held_r} + {2'b00, f_emit};
      end
      cp = f_emit ? f_cp : REPL_CP;
      if (f_open) begin
        partial_nxt = {10'd0, f_bits};
        exp_nxt     = f_need;
        held_nxt    = 2'd0;
      end else begin
        partial_nxt = '0;
        exp_nxt     = 2'd0;
        held_nxt    = 2'd0;
      end
    end else if (({1'b0, held_r} + 3'd1) >= {1'b0, exp_r}) begin
      cnt         = 3'd1;
      cp          = next_val;
      partial_nxt = '0;
      exp_nxt     = 2'd0;
      held_nxt    = 2'd0;
    end else if (in_text_end) begin
      // cut off: lead, held bytes and this byte each give U+FFFD
      cnt         = 3'd2 + {1'b0, held_r};
      partial_nxt = '0;
      exp_nxt     = 2'd0;
      held_nxt    = 2'd0;
    end else begin
      partial_nxt = next_val[PART_W-1:0];
      held_nxt    = held_r + 2'd1;
    end

    push.vld = accept && (cnt != '0);
    push.cnt = cnt;
    push.cp  = cp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      exp_r     <= 2'd0;
      held_r    <= 2'd0;
    end else if (accept) begin
      partial_r <= partial_nxt;
      exp_r     <= exp_nxt;
      held_r    <= held_nxt;
    end
  end

  `U8D_ASSERT_IMPLY(a_idle_no_held, exp_r == 2'd0, held_r == 2'd0)
  `U8D_ASSERT_IMPLY(a_held_below_exp, exp_r != 2'd0, held_r < exp_r)
  `U8D_ASSERT_IMPLY(a_push_cnt_range, push.vld, push.cnt <= 3'd4)

endmodule

### src/utf8d_emit.sv
module utf8d_emit
  import utf8d_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  burst_t          push,
  output logic            full,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [CP_W-1:0] out_code_point,
  output logic            out_run_last
);

`include "utf8_byte_stream_decoder_assert.svh"

  logic             head_vld_r, head_vld_nxt;
  logic [CNT_W-1:0] head_rem_r, head_rem_nxt;
  logic [CP_W-1:0]  head_cp_r, head_cp_nxt;
  logic             tail_vld_r, tail_vld_nxt;
  logic [CNT_W-1:0] tail_cnt_r, tail_cnt_nxt;
  logic [CP_W-1:0]  tail_cp_r, tail_cp_nxt;

  logic take;
  logic head_done;

  assign full           = tail_vld_r;
  assign out_valid      = head_vld_r;
  assign out_run_last   = head_rem_r == 3'd1;
  assign out_code_point = out_run_last ? head_cp_r : REPL_CP;

  assign take      = head_vld_r && !out_stall;
  assign head_done = take && (head_rem_r == 3'd1);

  always_comb begin
    head_vld_nxt = head_vld_r;
    head_rem_nxt = head_rem_r;
    head_cp_nxt  = head_cp_r;
    tail_vld_nxt = tail_vld_r;
    tail_cnt_nxt = tail_cnt_r;
    tail_cp_nxt  = tail_cp_r;
    if (!head_vld_r || head_done) begin
      if (tail_vld_r) begin
        head_vld_nxt = 1'b1;
        head_rem_nxt = tail_cnt_r;
        head_cp_nxt  = tail_cp_r;
        tail_vld_nxt = 1'b0;
      end else begin
        head_vld_nxt = push.vld;
        head_rem_nxt = push.cnt;
        head_cp_nxt  = push.cp;
      end
    end else begin
      if (take) begin
        head_rem_nxt = head_rem_r - 3'd1;
      end
      if (push.vld) begin
        tail_vld_nxt = 1'b1;
        tail_cnt_nxt = push.cnt;
        tail_cp_nxt  = push.cp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= 1'b0;
      head_rem_r <= '0;
      tail_vld_r <= 1'b0;
    end else begin
      head_vld_r <= head_vld_nxt;
      head_rem_r <= head_rem_nxt;
      tail_vld_r <= tail_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_cp_r  <= head_cp_nxt;
    tail_cnt_r <= tail_cnt_nxt;
    tail_cp_r  <= tail_cp_nxt;
  end

  `U8D_ASSERT_IMPLY(a_tail_needs_head, tail_vld_r, head_vld_r)
  `U8D_ASSERT_IMPLY(a_head_rem_range, head_vld_r, head_rem_r != 3'd0 && head_rem_r <= 3'd4)
  `U8D_ASSERT_ALWAYS(a_no_push_when_full, !(push.vld && tail_vld_r))

endmodule

### tb/utf8_decode_watch.sv
`timescale 1ns / 100ps

module utf8_decode_watch
  import utf8d_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_stall,
  input  logic [7:0]      in_data_byte,
  input  logic            in_text_end,
  input  logic            out_valid,
  input  logic            out_stall,
  input  logic [CP_W-1:0] out_code_point,
  input  logic            out_run_last,
  output int              fail_count,
  output int              cps_pending
);

  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_TAG   = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_TAG  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_TAG  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_TAG  = 8'hF0;

  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            run_last;
  } cp_result_t;

  cp_result_t expected_cps[$];

  // Decoder state mirrored from the block's behaviour.
  logic [CP_W-1:0] partial_cp  = '0;
  logic [1:0]      cont_needed = 2'd0;
  logic [1:0]      cont_held   = 2'd0;

  // Code points caused by the current byte, in order.
  logic [CP_W-1:0] burst_cp [4];
  int              burst_len = 0;
  int              errors = 0;

  task push_cp(input logic [CP_W-1:0] cp);
    burst_cp[burst_len] = cp;
    burst_len++;
  endtask

  task close_open();
    partial_cp  = '0;
    cont_needed = 2'd0;
    cont_held   = 2'd0;
  endtask

  // Replace the open lead and each held continuation byte.
  task abandon_open();
    int i;
    push_cp(REPL_CP);
    for (i = 0; i < int'(cont_held); i++) push_cp(REPL_CP);
    close_open();
  endtask

  task open_lead(input logic [7:0] b, input logic is_last);
    logic [1:0]      need;
    logic [CP_W-1:0] seed;
    need = 2'd0;
    seed = '0;
    if (b[7] == 1'b0) begin
      push_cp(CP_W'(b));
    end else begin
      if ((b & LEAD2_MASK) == LEAD2_TAG) begin
        need = 2'd1;
        seed = CP_W'(b[4:0]);
      end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
        need = 2'd2;
        seed = CP_W'(b[3:0]);
      end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
        need = 2'd3;
        seed = CP_W'(b[2:0]);
      end
      if (need == 2'd0 || is_last) begin
        push_cp(REPL_CP);
      end else begin
        partial_cp  = seed;
        cont_needed = need;
        cont_held   = 2'd0;
      end
    end
  endtask

  task decode_byte(input logic [7:0] b, input logic is_last);
    logic [CP_W-1:0] joined;
    cp_result_t      item;
    int              i;
    burst_len = 0;
    joined = {partial_cp[CP_W-7:0], b[5:0]};
    if (cont_needed == 2'd0) begin
      open_lead(b, is_last);
    end else if ((b & CONT_MASK) != CONT_TAG) begin
      abandon_open();
      open_lead(b, is_last);
    end else if (int'(cont_held) + 1 >= int'(cont_needed)) begin
      close_open();
      push_cp(joined);
    end else if (is_last) begin
      abandon_open();
      push_cp(REPL_CP);
    end else begin
      partial_cp = joined;
      cont_held++;
    end
    for (i = 0; i < burst_len; i++) begin
      item.cp       = burst_cp[i];
      item.run_last = (i == burst_len - 1);
      expected_cps.insert(expected_cps.size(), item);
    end
  endtask

  always @(posedge clk) begin
    cp_result_t want;
    if (!rst_n) begin
      expected_cps.delete();
      close_open();
    end else begin
      if (in_valid && !in_stall) decode_byte(in_data_byte, in_text_end);
      if (out_valid && !out_stall) begin
        if (expected_cps.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, actual code_point %h run_last %b",
                   $time, out_code_point, out_run_last);
        end else begin
          want = expected_cps.pop_front();
          if (want.cp !== out_code_point) begin
            errors++;
            $display("%0t: code_point mismatch: expected %h, actual %h",
                     $time, want.cp, out_code_point);
          end
          if (want.run_last !== out_run_last) begin
            errors++;
            $display("%0t: run_last mismatch: expected %b, actual %b",
                     $time, want.run_last, out_run_last);
          end
        end
      end
    end
    fail_count  <= errors;
    cps_pending <= expected_cps.size();
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import utf8d_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 64;
  // Byte counts at which the run moves from one phase to the next.
  localparam int PILEUP_AT   = 110;
  localparam int CALM_AT     = 230;
  localparam int TOTAL_BYTES = 260;

  logic            clk          = 1'b0;
  logic            rst_n        = 1'b0;
  logic            in_valid     = 1'b0;
  logic [7:0]      in_data_byte = 8'h00;
  logic            in_text_end  = 1'b0;
  logic            out_stall    = 1'b0;
  logic            in_stall;
  logic            out_valid;
  logic [CP_W-1:0] out_code_point;
  logic            out_run_last;
  int              fail_count;
  int              cps_pending;

  // Phase flags: calm switches off all idling for the closing stretch,
  // steady keeps the sender busy while the receiver holds off.
  logic calm         = 1'b0;
  logic hold_request = 1'b0;
  logic hold_taken   = 1'b0;
  logic steady       = 1'b0;
  int   stall_left   = 0;
  int   bytes_sent   = 0;
  int   cycles       = 0;

  utf8_byte_stream_decoder i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_text_end    (in_text_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_code_point (out_code_point),
    .out_run_last   (out_run_last)
  );

  utf8_decode_watch i_decode_watch (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_text_end    (in_text_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_code_point (out_code_point),
    .out_run_last   (out_run_last),
    .fail_count     (fail_count),
    .cps_pending    (cps_pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Receiver: random stall bursts, plus one long hold-off counted here so
  // that the burst queue fills and the input stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (hold_request && !hold_taken) begin
      out_stall  <= 1'b1;
      stall_left <= LONG_HOLD - 1;
      hold_taken <= 1'b1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("utf8_byte_stream_decoder regression: fail");
      $finish;
    end
  end

  // Offer one byte and hold it until the transaction completes. Insert a
  // random idle burst first unless the sender is meant to keep pushing.
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    if (!calm && !steady && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_text_end  <= is_last;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  // Drop valid and wait until every expected code point has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (cps_pending != 0);
  endtask

  // One chunk of random text: mostly well-formed sequences of random length
  // and content, the rest cut off by the end of text, interrupted by a fresh
  // byte, or plain noise.
  task automatic send_random_unit();
    logic [7:0]  unit_bytes [4];
    logic [20:0] cp;
    int          len;
    int          kind;
    int          keep;
    int          i;
    cp   = 21'($urandom);
    len  = $urandom_range(1, 4);
    kind = $urandom_range(0, 99);
    unit_bytes[1] = {2'b10, cp[5:0]};
    unit_bytes[2] = {2'b10, cp[5:0]};
    unit_bytes[3] = {2'b10, cp[5:0]};
    case (len)
      1: begin
        unit_bytes[0] = {1'b0, cp[6:0]};
      end
      2: begin
        unit_bytes[0] = {3'b110, cp[10:6]};
      end
      3: begin
        unit_bytes[0] = {4'b1110, cp[15:12]};
        unit_bytes[1] = {2'b10, cp[11:6]};
      end
      default: begin
        unit_bytes[0] = {5'b11110, cp[20:18]};
        unit_bytes[1] = {2'b10, cp[17:12]};
        unit_bytes[2] = {2'b10, cp[11:6]};
      end
    endcase
    if (kind < 72 || len == 1 && kind < 92) begin
      for (i = 0; i < len; i++) begin
        send_byte(unit_bytes[i], i == len - 1 && $urandom_range(0, 9) == 0);
      end
    end else if (kind < 82) begin
      // Text ends before the sequence is complete.
      keep = $urandom_range(1, len - 1);
      for (i = 0; i < keep; i++) send_byte(unit_bytes[i], i == keep - 1);
    end else if (kind < 92) begin
      // Any byte may land mid sequence, continuation or not.
      keep = $urandom_range(1, len - 1);
      for (i = 0; i < keep; i++) send_byte(unit_bytes[i], 1'b0);
      send_byte(8'($urandom), $urandom_range(0, 7) == 0);
    end else begin
      send_byte(8'($urandom), $urandom_range(0, 5) == 0);
    end
  endtask

  initial begin
    int k;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: ASCII extremes.
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    // Two, three and four byte forms.
    send_byte(8'hC2, 1'b0);
    send_byte(8'hA9, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hAC, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h9F, 1'b0);
    send_byte(8'h98, 1'b0);
    send_byte(8'h80, 1'b0);
    // Largest value a four byte lead can carry.
    send_byte(8'hF7, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    // Stray continuation, then a byte that is never a lead.
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    // Lead byte on the last byte of the text.
    send_byte(8'hC3, 1'b1);
    // Text ends mid sequence, with one continuation already held.
    send_byte(8'hF0, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(8'h80, 1'b1);
    // Non-continuation inside a sequence: four results from the last byte.
    send_byte(8'hF0, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h41, 1'b0);
    drain_results();

    while (bytes_sent < PILEUP_AT) send_random_unit();

    // Receiver holds off for a long stretch; send groups that each end by
    // breaking a sequence, so the burst queue fills and the input stalls.
    steady = 1'b1;
    hold_request <= 1'b1;
    for (k = 0; k < 8; k++) begin
      send_byte(8'hF0 | 8'($urandom_range(0, 7)), 1'b0);
      send_byte({2'b10, 6'($urandom)}, 1'b0);
      send_byte({2'b10, 6'($urandom)}, 1'b0);
      send_byte({1'b0, 7'($urandom)}, 1'b0);
    end
    steady = 1'b0;
    // Sender pauses until the backlog has fully drained.
    drain_results();

    while (bytes_sent < CALM_AT) send_random_unit();
    // Closing stretch runs at full rate on both sides.
    calm <= 1'b1;
    while (bytes_sent < TOTAL_BYTES) send_random_unit();

    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && cps_pending == 0) begin
      $display("utf8_byte_stream_decoder regression: pass");
    end else begin
      $display("utf8_byte_stream_decoder regression: fail");
    end
    $finish;
  end

endmodule
